/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the load cell calibration block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/lctc_pkg.sv */
// Types and constants of the load cell tare and calibration block.
package lctc_pkg;

    localparam int ALU_W      = 66;
    localparam int SAMPLE_W   = 49;
    localparam int VALUE_W    = 48;
    localparam int SUM_W      = 64;
    localparam int COUNT_W    = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_CODE_W = 14;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 64;
    localparam int DIV_STEPS  = 64;
    localparam int CNT_W      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_COUNT = 2'd2;

    localparam logic [CFG_W-1:0]   GAIN_RESET       = 32'h0001_0000;
    localparam logic [CFG_W-1:0]   OFFSET_RESET     = 32'h0000_0000;
    localparam logic [COUNT_W-1:0] TARE_COUNT_RESET = 16'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BIAS,
        ST_SUM,
        ST_ABS,
        ST_DIV,
        ST_FIX
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0]   sum;
        logic [VALUE_W-1:0] sat48;
        logic [SUM_W-1:0]   sat64;
    } t_alu_rsp;

endpackage

/* rtl/lctc_alu.sv */
// Shared add and subtract unit with saturation to 48 and 64 bits.
module lctc_alu (
    input  lctc_pkg::t_alu_req i_req,
    output lctc_pkg::t_alu_rsp o_rsp
);
    import lctc_pkg::*;

    logic             w_sub;
    logic [ALU_W-1:0] w_b;
    logic [ALU_W-1:0] w_sum;
    logic             w_fits48;
    logic             w_fits64;

    assign w_sub = (i_req.op == ALU_SUB);
    assign w_b   = w_sub ? ~i_req.b : i_req.b;
    assign w_sum = i_req.a + w_b + ALU_W'(w_sub);

    assign w_fits48 = (&w_sum[ALU_W-1:VALUE_W-1]) || (~|w_sum[ALU_W-1:VALUE_W-1]);
    assign w_fits64 = (&w_sum[ALU_W-1:SUM_W-1]) || (~|w_sum[ALU_W-1:SUM_W-1]);

    always_comb begin
        o_rsp.sum = w_sum;
        if (w_fits48) begin
            o_rsp.sat48 = w_sum[VALUE_W-1:0];
        end else begin
            o_rsp.sat48 = {w_sum[ALU_W-1], {(VALUE_W-1){~w_sum[ALU_W-1]}}};
        end
        if (w_fits64) begin
            o_rsp.sat64 = w_sum[SUM_W-1:0];
        end else begin
            o_rsp.sat64 = {w_sum[ALU_W-1], {(SUM_W-1){~w_sum[ALU_W-1]}}};
        end
    end

endmodule

/* rtl/load_cell_tare_and_linear_calibration.sv */
// Load cell reading calibration with tare averaging, top level.
//
// Input words arrive on s_axis: tdata carries the two sensor bytes and tuser
// selects a measurement (0) or a tare sample (1). Output words leave on m_axis:
// tdata carries the corrected value or the new bias and the raw code, and tuser
// flags a new bias. Gain, offset and tare count are written on the cfg channel.
// One shared add and subtract unit does all arithmetic under a small sequencer.
// A measurement passes RAW_BITS shift-and-add steps of the multiply and one bias
// subtract on its way to the output register. A tare sample that does not
// complete its run is only added to the tare sum and gives no output word. For a
// completing tare sample, the magnitude of the 64-bit sum is divided by the sample
// count in the restoring divider at one bit a cycle, and the sign is then restored
// before the new bias reaches the output register.
// The block accepts one word at a time; s_axis_tready is high only while idle.
// A finished word waits in the output register, and the next input word is
// accepted meanwhile; its result stalls until the output register is free.
// Reset restores gain 1.0, offset zero, tare count 16, and clears the bias,
// the tare sum and the sample count. Neither channel is ready during reset.
`include "assert_macros.svh"

module load_cell_tare_and_linear_calibration #(
    parameter int RAW_BITS = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lctc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lctc_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: high_byte[7:0], low_byte[15:8].
    input  logic [lctc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // Field: func.
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: value[47:0], raw_code[61:48], zero fill[63:62].
    output logic [lctc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Field: tare_done.
    output logic                                  m_axis_tuser
);
    import lctc_pkg::*;

    localparam logic [7:0] HIGH_MASK = 8'((1 << (RAW_BITS - 8)) - 1);

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_cnt;

    logic [CFG_W-1:0]      r_gain;
    logic [CFG_W-1:0]      r_offset;
    logic [COUNT_W-1:0]    r_tare_count;
    logic [VALUE_W-1:0]    r_bias;
    logic [SUM_W-1:0]      r_tare_sum;
    logic [COUNT_W-1:0]    r_tare_seen;

    logic                  r_func;
    logic [RAW_BITS-1:0]   r_code;
    logic [RAW_BITS-1:0]   r_mplier;
    logic [VALUE_W-1:0]    r_mcand;
    logic [SAMPLE_W-1:0]   r_acc;
    logic [SUM_W-1:0]      r_quo;
    logic [COUNT_W-1:0]    r_rem;
    logic [COUNT_W-1:0]    r_divisor;
    logic                  r_neg;

    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    logic                  r_out_done;
    logic [OUT_CODE_W-1:0] r_out_code;

    logic [15:0]           w_code_full;
    logic [15:0]           w_code_ext;
    logic                  w_in_accept;
    logic                  w_out_free;
    logic                  w_out_load;
    logic [COUNT_W:0]      w_seen;
    logic [COUNT_W:0]      w_limit;
    logic                  w_tare_more;
    logic [COUNT_W:0]      w_rem_shift;
    logic                  w_last_mul;
    logic                  w_last_div;
    logic [ALU_W-1:0]      w_acc_ext;

    t_alu_req              w_alu_req;
    t_alu_rsp              w_alu_rsp;

    lctc_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_code, r_out_value};
    assign m_axis_tuser  = r_out_done;

    assign w_code_full = {s_axis_tdata[7:0] & HIGH_MASK, s_axis_tdata[15:8]};
    assign w_code_ext  = 16'(r_code);
    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_out_load  = ((r_state == ST_BIAS) || (r_state == ST_FIX)) && w_out_free;
    assign w_seen      = {1'b0, r_tare_seen} + (COUNT_W+1)'(1);
    assign w_limit     = (r_tare_count == '0) ? (COUNT_W+1)'(1) : {1'b0, r_tare_count};
    assign w_tare_more = (w_seen < w_limit);
    assign w_rem_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_last_mul  = (r_cnt == CNT_W'(RAW_BITS - 1));
    assign w_last_div  = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign w_acc_ext   = {{(ALU_W-SAMPLE_W){r_acc[SAMPLE_W-1]}}, r_acc};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_last_mul) begin
                    n_state = r_func ? ST_SUM : ST_BIAS;
                end
            end
            ST_BIAS: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SUM: begin
                n_state = w_tare_more ? ST_IDLE : ST_ABS;
            end
            ST_ABS: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_last_div) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_alu_req.op = ALU_ADD;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;
        case (r_state)
            ST_MUL: begin
                w_alu_req.a = w_acc_ext;
                if (r_mplier[0]) begin
                    w_alu_req.b = {{(ALU_W-VALUE_W){r_mcand[VALUE_W-1]}}, r_mcand};
                end
            end
            ST_BIAS: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = w_acc_ext;
                w_alu_req.b  = {{(ALU_W-VALUE_W){r_bias[VALUE_W-1]}}, r_bias};
            end
            ST_SUM: begin
                w_alu_req.a = {{(ALU_W-SUM_W){r_tare_sum[SUM_W-1]}}, r_tare_sum};
                w_alu_req.b = w_acc_ext;
            end
            ST_ABS: begin
                w_alu_req.op = r_neg ? ALU_SUB : ALU_ADD;
                w_alu_req.b  = {{(ALU_W-SUM_W){r_quo[SUM_W-1]}}, r_quo};
            end
            ST_DIV: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = ALU_W'(w_rem_shift);
                w_alu_req.b  = ALU_W'(r_divisor);
            end
            ST_FIX: begin
                w_alu_req.op = r_neg ? ALU_SUB : ALU_ADD;
                w_alu_req.b  = ALU_W'(r_quo);
            end
            default: begin
                w_alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_gain       <= GAIN_RESET;
            r_offset     <= OFFSET_RESET;
            r_tare_count <= TARE_COUNT_RESET;
            r_bias       <= '0;
            r_tare_sum   <= '0;
            r_tare_seen  <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_MUL) || (r_state == ST_DIV)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAIN:       r_gain <= i_cfg_data;
                    CFG_OFFSET:     r_offset <= i_cfg_data;
                    CFG_TARE_COUNT: r_tare_count <= i_cfg_data[COUNT_W-1:0];
                    default: begin
                        r_gain <= r_gain;
                    end
                endcase
            end
            if (r_state == ST_SUM) begin
                if (w_tare_more) begin
                    r_tare_sum  <= w_alu_rsp.sat64;
                    r_tare_seen <= w_seen[COUNT_W-1:0];
                end else begin
                    r_tare_sum  <= '0;
                    r_tare_seen <= '0;
                end
            end
            if ((r_state == ST_FIX) && w_out_free) begin
                r_bias <= w_alu_rsp.sat48;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    r_func   <= s_axis_tuser;
                    r_code   <= w_code_full[RAW_BITS-1:0];
                    r_mplier <= w_code_full[RAW_BITS-1:0];
                    r_mcand  <= {{(VALUE_W-CFG_W){r_gain[CFG_W-1]}}, r_gain};
                    r_acc    <= {{(SAMPLE_W-CFG_W){r_offset[CFG_W-1]}}, r_offset};
                end
            end
            ST_MUL: begin
                r_acc    <= w_alu_rsp.sum[SAMPLE_W-1:0];
                r_mplier <= r_mplier >> 1;
                r_mcand  <= r_mcand << 1;
            end
            ST_BIAS: begin
                if (w_out_free) begin
                    r_out_value <= w_alu_rsp.sat48;
                    r_out_done  <= 1'b0;
                    r_out_code  <= w_code_ext[OUT_CODE_W-1:0];
                end
            end
            ST_SUM: begin
                r_quo     <= w_alu_rsp.sat64;
                r_neg     <= w_alu_rsp.sat64[SUM_W-1];
                r_divisor <= w_seen[COUNT_W-1:0];
                r_rem     <= '0;
            end
            ST_ABS: begin
                r_quo <= w_alu_rsp.sum[SUM_W-1:0];
            end
            ST_DIV: begin
                r_quo <= {r_quo[SUM_W-2:0], ~w_alu_rsp.sum[ALU_W-1]};
                if (w_alu_rsp.sum[ALU_W-1]) begin
                    r_rem <= w_rem_shift[COUNT_W-1:0];
                end else begin
                    r_rem <= w_alu_rsp.sum[COUNT_W-1:0];
                end
            end
            ST_FIX: begin
                if (w_out_free) begin
                    r_out_value <= w_alu_rsp.sat48;
                    r_out_done  <= 1'b1;
                    r_out_code  <= w_code_ext[OUT_CODE_W-1:0];
                end
            end
            default: begin
                r_func <= r_func;
            end
        endcase
    end

    `ASSERT_CLK(a_rem_below_divisor, (r_state == ST_DIV) |-> (r_rem < r_divisor), "Bad remainder.")
    `ASSERT_CLK(a_seen_in_range, r_tare_seen != {COUNT_W{1'b1}}, "Tare count out of range.")
    `ASSERT_NEXT(a_accept_starts_mul, w_in_accept, r_state == ST_MUL, "Multiply did not start.")
    `ASSERT_CLK(a_mul_count, (r_state == ST_MUL) |-> (r_cnt < CNT_W'(RAW_BITS)), "Multiply overran.")

endmodule
